>>> rtl/tcd_pkg.sv
// shared types, codes and helpers for the timed cue dispatcher
package tcd_pkg;

  localparam int MAX_CUES = 16;
  localparam int IDX_W    = $clog2(MAX_CUES);
  localparam int CNT_W    = $clog2(MAX_CUES + 1);
  localparam int NUM_CHANNELS = 4;
  localparam int MODE_SHIFT   = 12;
  localparam logic [11:0] VALUE_MASK = 12'hFFF;

  localparam logic [1:0] REQ_LOAD  = 2'd0;
  localparam logic [1:0] REQ_START = 2'd1;
  localparam logic [1:0] REQ_TICK  = 2'd2;
  localparam logic [1:0] REQ_STOP  = 2'd3;

  localparam logic [1:0] ACT_CLEAR    = 2'd0;
  localparam logic [1:0] ACT_FILL     = 2'd1;
  localparam logic [1:0] ACT_BLACKOUT = 2'd2;

  localparam logic [3:0] MODE_ALWAYS    = 4'd0;
  localparam logic [3:0] MODE_ID_EQ     = 4'd1;
  localparam logic [3:0] MODE_GROUP_EQ  = 4'd2;
  localparam logic [3:0] MODE_BIT_SET   = 4'd3;
  localparam logic [3:0] MODE_ID_NE     = 4'd4;
  localparam logic [3:0] MODE_GROUP_NE  = 4'd5;
  localparam logic [3:0] MODE_BIT_CLEAR = 4'd6;

  localparam logic [1:0] CFG_UNIT_ID    = 2'd0;
  localparam logic [1:0] CFG_UNIT_GROUP = 2'd1;
  localparam logic [1:0] CFG_CUE_COUNT  = 2'd2;

  typedef struct packed {
    logic [15:0] group_word;
    logic [1:0]  action;
    logic [7:0]  channel;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
  } cue_t;

  typedef struct packed {
    logic        adv;
    logic        kill;
    logic        begin_scan;
    logic        clear_fired;
    logic [31:0] now;
  } cell_ctl_t;

  typedef struct packed {
    logic       hit;
    logic       led;
    logic [3:0] mask;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } cell_res_t;

  function automatic logic group_match(input logic [15:0] gw, input logic [11:0] uid,
                                       input logic [3:0] ugrp);
    logic [3:0]  mode;
    logic [11:0] value;
    logic [15:0] value_ext;
    logic        bit_on;
    logic        m;
    mode      = gw[15:MODE_SHIFT];
    value     = gw[11:0] & VALUE_MASK;
    // group numbers above the value width see a clear bit
    value_ext = {4'd0, value};
    bit_on    = value_ext[ugrp];
    case (mode)
      MODE_ALWAYS:    m = 1'b1;
      MODE_ID_EQ:     m = (uid == value);
      MODE_GROUP_EQ:  m = ({8'd0, ugrp} == value);
      MODE_BIT_SET:   m = bit_on;
      MODE_ID_NE:     m = (uid != value);
      MODE_GROUP_NE:  m = ({8'd0, ugrp} != value);
      MODE_BIT_CLEAR: m = !bit_on;
      default:        m = 1'b0;
    endcase
    return m;
  endfunction

endpackage

>>> rtl/tcd_cell.sv
// one cue slot of the scan chain: entry storage, fired mark and scan token
module tcd_cell (
  input  logic                clk,
  input  logic                rst,
  input  tcd_pkg::cell_ctl_t  ctl,
  input  logic                wr_en,
  input  logic [31:0]         wr_start,
  input  tcd_pkg::cue_t       wr_cue,
  input  logic [11:0]         unit_id,
  input  logic [3:0]          unit_group,
  input  logic                tok_in,
  output logic                tok_out,
  output tcd_pkg::cell_res_t  res
);
  import tcd_pkg::*;

  logic [31:0] cue_start;
  cue_t        cue;
  logic        fired;
  logic        token;
  logic        hit;
  logic        matched;
  logic        ch_ok;
  logic [7:0]  ch_m1;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      cue_start <= wr_start;
      cue       <= wr_cue;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.kill) begin
      token <= 1'b0;
    end else if (ctl.adv || ctl.begin_scan) begin
      token <= tok_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.clear_fired) begin
      fired <= 1'b0;
    end else if (hit) begin
      fired <= 1'b1;
    end
  end

  assign tok_out = token;

  always_comb begin
    hit     = token && ctl.adv && !fired && (cue_start <= ctl.now);
    matched = group_match(cue.group_word, unit_id, unit_group);
    ch_ok   = (cue.channel >= 8'd1) && (cue.channel <= 8'(NUM_CHANNELS));
    ch_m1   = cue.channel - 8'd1;
    res     = '0;
    res.hit = hit;
    if (hit && matched) begin
      if (cue.action == ACT_BLACKOUT) begin
        res.led  = 1'b1;
        res.mask = 4'hF;
      end else if ((cue.action == ACT_CLEAR || cue.action == ACT_FILL) && ch_ok) begin
        res.led  = 1'b1;
        res.mask = 4'd1 << ch_m1[1:0];
        if (cue.action == ACT_FILL) begin
          res.red   = cue.red;
          res.green = cue.green;
          res.blue  = cue.blue;
        end
      end
    end
  end

endmodule

>>> rtl/timed_cue_dispatcher.sv
// timed cue dispatcher top level: request decode, scan control and result register
// Requests arrive on the in channel (in_valid / in_stall): load an entry, start,
// tick or stop. Each request yields a run of results on the out channel
// (out_valid / out_stall); the final result of a run has last set and carries
// the status (is_playing, complete, fired_total).
// A load, start or stop is accepted, then the status state loads the status result.
// A tick while playing walks a token down a row of cue cells, one cell per cycle
// while the output can take a result, over the active cue count (at most
// 16); each due, unfired cue with a matching group, valid action and channel
// emits an LED result in table order. A new request is taken only after the
// previous run's last result has been loaded into the output register.
// The output register holds a result while out_stall is high, and the scan
// pauses until it can take the next one.
// Configuration writes (cfg_valid / cfg_ready, always ready) set unit_id, unit_group
// and cue_count; the user must write them between requests, the block does not check.
// Reset (rst, synchronous) stops playback, clears the fired marks, the fired
// count and out_valid; cue_count returns to 1. Table entries hold
// nothing defined until loaded.
module timed_cue_dispatcher (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [11:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  req_type,
  input  logic [3:0]  cue_index,
  input  logic [31:0] start_time,
  input  logic [15:0] group_word,
  input  logic [1:0]  action,
  input  logic [7:0]  channel,
  input  logic [7:0]  red,
  input  logic [7:0]  green,
  input  logic [7:0]  blue,
  input  logic [31:0] tick_time,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  channel_mask,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue,
  output logic        led_valid,
  output logic        is_playing,
  output logic        complete,
  output logic [4:0]  fired_total,
  output logic        last
);
  import tcd_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SCAN   = 3'b010,
    ST_STATUS = 3'b100
  } state_t;

  state_t      state;
  state_t      state_next;
  logic [11:0] unit_id;
  logic [3:0]  unit_group;
  logic [4:0]  cue_count;
  logic [CNT_W-1:0] fired_count;
  logic        playing;
  logic        chk;
  logic [31:0] now;
  logic [IDX_W-1:0] pos;

  logic [CNT_W-1:0] n_act;
  logic        in_acc;
  logic        out_free;
  logic        adv;
  logic        last_step;
  logic        tick_go;
  logic        start_go;
  logic        stop_go;
  logic        status_go;
  logic        cmp;
  cell_ctl_t   ctl;
  cue_t        wr_cue;
  cell_res_t   res [MAX_CUES];
  cell_res_t   sel;
  logic [MAX_CUES:0] tok;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      unit_id    <= '0;
      unit_group <= '0;
      cue_count  <= 5'd1;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_UNIT_ID:    unit_id    <= cfg_data;
        CFG_UNIT_GROUP: unit_group <= cfg_data[3:0];
        CFG_CUE_COUNT:  cue_count  <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    n_act     = (CNT_W'(cue_count) > CNT_W'(MAX_CUES)) ? CNT_W'(MAX_CUES) : CNT_W'(cue_count);
    in_stall  = (state != ST_IDLE);
    in_acc    = in_valid && !in_stall;
    out_free  = !out_valid || !out_stall;
    adv       = (state == ST_SCAN) && out_free;
    last_step = adv && (pos == IDX_W'(n_act - CNT_W'(1)));
    tick_go   = in_acc && (req_type == REQ_TICK) && playing && (n_act != '0);
    start_go  = in_acc && (req_type == REQ_START) && (n_act != '0);
    stop_go   = in_acc && (req_type == REQ_STOP);
    status_go = (state == ST_STATUS) && out_free;
    cmp       = chk && (fired_count >= n_act);

    ctl.adv         = adv;
    ctl.kill        = last_step;
    ctl.begin_scan  = tick_go;
    ctl.clear_fired = start_go;
    ctl.now         = now;

    wr_cue.group_word = group_word;
    wr_cue.action     = action;
    wr_cue.channel    = channel;
    wr_cue.red        = red;
    wr_cue.green      = green;
    wr_cue.blue       = blue;
  end

  assign tok[0] = tick_go;

  for (genvar i = 0; i < MAX_CUES; i++) begin : g_cell
    tcd_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctl        (ctl),
      .wr_en      (in_acc && (req_type == REQ_LOAD) && (cue_index == IDX_W'(i))),
      .wr_start   (start_time),
      .wr_cue     (wr_cue),
      .unit_id    (unit_id),
      .unit_group (unit_group),
      .tok_in     (tok[i]),
      .tok_out    (tok[i+1]),
      .res        (res[i])
    );
  end

  // only the token holder drives a non-zero result
  always_comb begin
    sel = '0;
    for (int i = 0; i < MAX_CUES; i++) begin
      sel = sel | res[i];
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (in_acc) state_next = tick_go ? ST_SCAN : ST_STATUS;
      ST_SCAN:   if (last_step) state_next = ST_STATUS;
      ST_STATUS: if (out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      fired_count <= '0;
      playing     <= 1'b0;
      chk         <= 1'b0;
    end else begin
      state <= state_next;
      if (in_acc) begin
        chk <= (req_type == REQ_TICK) && playing;
      end
      if (start_go) begin
        fired_count <= '0;
      end else if (sel.hit) begin
        fired_count <= fired_count + CNT_W'(1);
      end
      if (start_go) begin
        playing <= 1'b1;
      end else if (stop_go) begin
        playing <= 1'b0;
      end else if (status_go && cmp) begin
        playing <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tick_go) begin
      now <= tick_time;
      pos <= '0;
    end else if (adv) begin
      pos <= pos + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((adv && sel.led) || status_go) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && sel.led) begin
      channel_mask <= sel.mask;
      out_red      <= sel.red;
      out_green    <= sel.green;
      out_blue     <= sel.blue;
      led_valid    <= 1'b1;
      is_playing   <= playing;
      complete     <= 1'b0;
      fired_total  <= 5'(fired_count + CNT_W'(1));
      last         <= 1'b0;
    end else if (status_go) begin
      channel_mask <= '0;
      out_red      <= '0;
      out_green    <= '0;
      out_blue     <= '0;
      led_valid    <= 1'b0;
      is_playing   <= playing && !cmp;
      complete     <= cmp;
      fired_total  <= 5'(fired_count);
      last         <= 1'b1;
    end
  end

endmodule
